// File: hw/rtl/qcsv_pkg.sv
package qcsv_pkg;

  localparam int FIELD_INDEX_BITS = 8;
  localparam int IDX_EXT_BITS = (FIELD_INDEX_BITS > 8) ? FIELD_INDEX_BITS : 8;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] PH_OPEN  = 2'd0;
  localparam logic [1:0] PH_FIELD = 2'd1;
  localparam logic [1:0] PH_QUOTE = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_FEND  = 2'd1;
  localparam logic [1:0] KIND_REND  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_NOOPEN = 2'd1;
  localparam logic [1:0] ERR_BADAFT = 2'd2;
  localparam logic [1:0] ERR_UNTERM = 2'd3;

  typedef logic [FIELD_INDEX_BITS-1:0] count_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [7:0] field_index;
    logic [1:0] error_kind;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t result;
    logic [1:0] phase_next;
    count_t  count_next;
  } step_t;

  function automatic logic [7:0] clamp_index(input count_t count);
    logic [IDX_EXT_BITS-1:0] ext;
    ext = IDX_EXT_BITS'(count);
    if (ext > IDX_EXT_BITS'(255)) begin
      return 8'hFF;
    end
    return ext[7:0];
  endfunction

endpackage

// File: hw/rtl/quoted_csv_field_parser.sv
// Parser for CSV text whose fields are all double-quoted. One byte word
// enters per cycle while the result side accepts; each word gives at most
// one result word: a content byte, a field end, a record end, or an error
// (missing opening quote, bad byte after a closing quote, unterminated
// field), after which input is skipped up to the next newline or last byte.
// A doubled quote inside a field yields one quote. An accepted word lands
// in the input register; when it advances, the phase and field-index update
// is applied and the result register is loaded, and a word that gives a
// result cannot advance while a held result waits. Sustained rate is one
// word per cycle while the result side accepts; words that produce no result never wait for the result side.
module quoted_csv_field_parser import qcsv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  item_t      s1;
  logic       s1_valid;
  logic [1:0] phase;
  count_t     count;
  step_t      step;
  logic       s1_adv;

  qcsv_step u_step (
    .phase (phase),
    .count (count),
    .item  (s1),
    .step  (step)
  );

  assign s1_adv     = s1_valid && (!step.emit || !result_valid || result_ready);
  assign item_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      phase        <= PH_OPEN;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (s1_adv) begin
        phase <= step.phase_next;
        count <= step.count_next;
      end
      if (s1_adv && step.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1 <= item;
    end
    if (s1_adv && step.emit) begin
      result <= step.result;
    end
  end

  a_err_kind_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.kind == KIND_ERROR) == (result.error_kind != ERR_NONE)))
    else $error("error_kind disagrees with kind");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind != KIND_BYTE) |-> (result.out_byte == CH_NUL))
    else $error("non-byte result carries data");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1.last_byte) |=> (phase == PH_OPEN && count == '0))
    else $error("state not cleared after last byte");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && phase == PH_SKIP) |-> !step.emit)
    else $error("result produced while skipping");

endmodule

// File: hw/rtl/qcsv_step.sv
module qcsv_step import qcsv_pkg::*; (
  input  logic [1:0] phase,
  input  count_t     count,
  input  item_t      item,
  output step_t      step
);

  logic [7:0] idx;
  logic       rec_reset;
  logic       bump;

  always_comb begin
    idx = clamp_index(count);
    rec_reset = 1'b0;
    bump = 1'b0;
    step.emit = 1'b0;
    step.result.out_byte = CH_NUL;
    step.result.kind = KIND_BYTE;
    step.result.field_index = idx;
    step.result.error_kind = ERR_NONE;
    step.phase_next = phase;
    step.count_next = count;

    unique case (phase)
      PH_OPEN: begin
        if (item.data_byte == CH_QUOTE) begin
          if (item.last_byte) begin
            step.emit = 1'b1;
            step.result.kind = KIND_ERROR;
            step.result.error_kind = ERR_UNTERM;
          end
          step.phase_next = PH_FIELD;
        end else begin
          step.emit = 1'b1;
          step.result.kind = KIND_ERROR;
          step.result.error_kind = ERR_NOOPEN;
          if (item.data_byte == CH_NL) begin
            step.phase_next = PH_OPEN;
            rec_reset = 1'b1;
          end else begin
            step.phase_next = PH_SKIP;
          end
        end
      end
      PH_FIELD: begin
        if (item.data_byte == CH_QUOTE) begin
          if (item.last_byte) begin
            step.emit = 1'b1;
            step.result.kind = KIND_REND;
          end
          step.phase_next = PH_QUOTE;
        end else if (item.data_byte == CH_NL) begin
          step.emit = 1'b1;
          step.result.kind = KIND_ERROR;
          step.result.error_kind = ERR_UNTERM;
          step.phase_next = PH_OPEN;
          rec_reset = 1'b1;
        end else if (item.last_byte) begin
          step.emit = 1'b1;
          step.result.kind = KIND_ERROR;
          step.result.error_kind = ERR_UNTERM;
        end else begin
          step.emit = 1'b1;
          step.result.out_byte = item.data_byte;
        end
      end
      PH_QUOTE: begin
        step.emit = 1'b1;
        if (item.data_byte == CH_QUOTE) begin
          if (item.last_byte) begin
            step.result.kind = KIND_ERROR;
            step.result.error_kind = ERR_UNTERM;
          end else begin
            step.result.out_byte = CH_QUOTE;
          end
          step.phase_next = PH_FIELD;
        end else if (item.data_byte == CH_COMMA) begin
          if (item.last_byte) begin
            step.result.kind = KIND_ERROR;
            step.result.error_kind = ERR_NOOPEN;
          end else begin
            step.result.kind = KIND_FEND;
            bump = 1'b1;
          end
          step.phase_next = PH_OPEN;
        end else if (item.data_byte == CH_NL) begin
          step.result.kind = KIND_REND;
          step.phase_next = PH_OPEN;
          rec_reset = 1'b1;
        end else begin
          step.result.kind = KIND_ERROR;
          step.result.error_kind = ERR_BADAFT;
          step.phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (item.data_byte == CH_NL) begin
          step.phase_next = PH_OPEN;
          rec_reset = 1'b1;
        end
      end
      default: begin
        step.phase_next = PH_OPEN;
      end
    endcase

    if (bump && (count != '1)) begin
      step.count_next = count + count_t'(1);
    end
    if (rec_reset || item.last_byte) begin
      step.count_next = '0;
    end
    if (item.last_byte) begin
      step.phase_next = PH_OPEN;
    end
  end

endmodule
